### design/lss_pkg.sv
package lss_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int DOT_W   = PROD_W + 1;
    localparam int S_W     = PROD_W;
    localparam int FRAC_W  = 16;
    localparam int Q_W     = 32;
    localparam int M_W     = 64;
    localparam int SR_W    = Q_W + 2;
    localparam int W_STEPS = Q_W;
    localparam int D_STEPS = M_W;
    localparam int STEPS   = M_W + Q_W;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // One classified item as it waits between the front and back parts.
    typedef struct packed {
        logic [S_W-1:0]          s;
        logic signed [DOT_W-1:0] t0;
        logic signed [DOT_W-1:0] t1;
        logic                    degen;
    } item_t;

    typedef struct packed {
        logic [S_W-1:0] s;
        logic           degen;
        logic           s_one;
        logic           neg0;
        logic           neg1;
        logic [S_W-1:0] mag0;
        logic [S_W-1:0] mag1;
    } mag_t;

    typedef struct packed {
        logic [S_W-1:0]  s;
        logic            degen;
        logic            s_one;
        logic            neg0;
        logic            neg1;
        logic            ovf0;
        logic            ovf1;
        logic [S_W-1:0]  wr0;
        logic [S_W-1:0]  wr1;
        logic [Q_W-1:0]  wl0;
        logic [Q_W-1:0]  wl1;
        logic [Q_W-1:0]  wq0;
        logic [Q_W-1:0]  wq1;
        logic [S_W-1:0]  dr;
        logic [M_W-1:0]  dq;
        logic [SR_W-1:0] sr;
        logic [Q_W-1:0]  root;
    } stage_t;

endpackage

### design/lss_front.sv
module lss_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic signed [lss_pkg::COORD_W-1:0] point_x,
    input  logic signed [lss_pkg::COORD_W-1:0] point_y,
    input  logic signed [lss_pkg::COORD_W-1:0] point_z,
    input  logic signed [lss_pkg::COORD_W-1:0] first_node_x,
    input  logic signed [lss_pkg::COORD_W-1:0] first_node_y,
    input  logic signed [lss_pkg::COORD_W-1:0] first_node_z,
    input  logic signed [lss_pkg::COORD_W-1:0] second_node_x,
    input  logic signed [lss_pkg::COORD_W-1:0] second_node_y,
    input  logic signed [lss_pkg::COORD_W-1:0] second_node_z,
    output logic                              push,
    output lss_pkg::item_t                    push_item,
    input  logic                              queue_ready
);

    logic [2:0]                         v_reg;
    logic                               adv;
    logic signed [lss_pkg::DIFF_W-1:0]  e_reg [3];
    logic signed [lss_pkg::DIFF_W-1:0]  a_reg [3];
    logic signed [lss_pkg::DIFF_W-1:0]  b_reg [3];
    logic signed [lss_pkg::PROD_W-1:0]  ee_reg [3];
    logic signed [lss_pkg::PROD_W-1:0]  ae_reg [3];
    logic signed [lss_pkg::PROD_W-1:0]  be_reg [3];
    logic signed [lss_pkg::DIFF_W-1:0]  p_ext [3];
    logic signed [lss_pkg::DIFF_W-1:0]  n0_ext [3];
    logic signed [lss_pkg::DIFF_W-1:0]  n1_ext [3];
    logic signed [lss_pkg::SUM_W-1:0]   s_sum;
    logic signed [lss_pkg::SUM_W-1:0]   t0_sum;
    logic signed [lss_pkg::SUM_W-1:0]   t1_sum;
    lss_pkg::item_t                     item_reg;
    lss_pkg::item_t                     item_next;

    assign adv        = !v_reg[2] || queue_ready;
    assign item_ready = adv;
    assign push       = v_reg[2] && queue_ready;
    assign push_item  = item_reg;

    assign p_ext[0]  = lss_pkg::DIFF_W'(point_x);
    assign p_ext[1]  = lss_pkg::DIFF_W'(point_y);
    assign p_ext[2]  = lss_pkg::DIFF_W'(point_z);
    assign n0_ext[0] = lss_pkg::DIFF_W'(first_node_x);
    assign n0_ext[1] = lss_pkg::DIFF_W'(first_node_y);
    assign n0_ext[2] = lss_pkg::DIFF_W'(first_node_z);
    assign n1_ext[0] = lss_pkg::DIFF_W'(second_node_x);
    assign n1_ext[1] = lss_pkg::DIFF_W'(second_node_y);
    assign n1_ext[2] = lss_pkg::DIFF_W'(second_node_z);

    always_comb
    begin
        s_sum  = lss_pkg::SUM_W'(ee_reg[0]) + lss_pkg::SUM_W'(ee_reg[1])
               + lss_pkg::SUM_W'(ee_reg[2]);
        t0_sum = lss_pkg::SUM_W'(be_reg[0]) + lss_pkg::SUM_W'(be_reg[1])
               + lss_pkg::SUM_W'(be_reg[2]);
        t1_sum = lss_pkg::SUM_W'(ae_reg[0]) + lss_pkg::SUM_W'(ae_reg[1])
               + lss_pkg::SUM_W'(ae_reg[2]);
        item_next.s     = s_sum[lss_pkg::S_W-1:0];
        item_next.t0    = t0_sum[lss_pkg::DOT_W-1:0];
        item_next.t1    = t1_sum[lss_pkg::DOT_W-1:0];
        item_next.degen = (s_sum == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[1:0], item_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e_reg[i]  <= n1_ext[i] - n0_ext[i];
                a_reg[i]  <= p_ext[i] - n0_ext[i];
                b_reg[i]  <= p_ext[i] - n1_ext[i];
                ee_reg[i] <= e_reg[i] * e_reg[i];
                ae_reg[i] <= a_reg[i] * e_reg[i];
                be_reg[i] <= b_reg[i] * e_reg[i];
            end
            item_reg <= item_next;
        end
    end

endmodule

### design/lss_queue.sv
module lss_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lss_pkg::item_t push_item,
    output logic           queue_ready,
    input  logic           pop,
    output logic           queue_valid,
    output lss_pkg::item_t pop_item
);

    lss_pkg::item_t               mem_reg [lss_pkg::QDEPTH];
    logic [lss_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [lss_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [lss_pkg::QPTR_W:0]     count_reg;

    assign queue_ready = (count_reg != (lss_pkg::QPTR_W+1)'(lss_pkg::QDEPTH));
    assign queue_valid = (count_reg != '0);
    assign pop_item    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### design/lss_back.sv
module lss_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         queue_valid,
    input  lss_pkg::item_t               pop_item,
    output logic                         pop,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [lss_pkg::COORD_W-1:0]  weight_first,
    output logic [lss_pkg::COORD_W-1:0]  weight_second,
    output logic [lss_pkg::COORD_W-1:0]  slope_first,
    output logic [lss_pkg::COORD_W-1:0]  slope_second,
    output logic                         degenerate
);

    // One step of each shift-subtract unit. The weight quotients take the
    // first steps, the reciprocal of S the first 64, the square root the rest.
    function automatic lss_pkg::stage_t bk_step(lss_pkg::stage_t a, logic do_w, logic do_d);
        lss_pkg::stage_t         r;
        logic [lss_pkg::S_W:0]   t0;
        logic [lss_pkg::S_W:0]   t1;
        logic [lss_pkg::S_W:0]   td;
        logic [lss_pkg::S_W:0]   sx;
        logic [lss_pkg::SR_W+1:0] ts;
        logic [lss_pkg::SR_W+1:0] tr;
        r  = a;
        sx = {1'b0, a.s};
        t0 = {a.wr0, a.wl0[lss_pkg::Q_W-1]};
        t1 = {a.wr1, a.wl1[lss_pkg::Q_W-1]};
        td = {a.dr, 1'b0};
        ts = {a.sr, a.dq[lss_pkg::M_W-1 -: 2]};
        tr = {2'b00, a.root, 2'b01};
        if (do_w)
        begin
            r.wl0 = {a.wl0[lss_pkg::Q_W-2:0], 1'b0};
            r.wl1 = {a.wl1[lss_pkg::Q_W-2:0], 1'b0};
            if (t0 >= sx)
            begin
                r.wr0 = lss_pkg::S_W'(t0 - sx);
                r.wq0 = {a.wq0[lss_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                r.wr0 = t0[lss_pkg::S_W-1:0];
                r.wq0 = {a.wq0[lss_pkg::Q_W-2:0], 1'b0};
            end
            if (t1 >= sx)
            begin
                r.wr1 = lss_pkg::S_W'(t1 - sx);
                r.wq1 = {a.wq1[lss_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                r.wr1 = t1[lss_pkg::S_W-1:0];
                r.wq1 = {a.wq1[lss_pkg::Q_W-2:0], 1'b0};
            end
        end
        if (do_d)
        begin
            if (td >= sx)
            begin
                r.dr = lss_pkg::S_W'(td - sx);
                r.dq = {a.dq[lss_pkg::M_W-2:0], 1'b1};
            end
            else
            begin
                r.dr = td[lss_pkg::S_W-1:0];
                r.dq = {a.dq[lss_pkg::M_W-2:0], 1'b0};
            end
        end
        else
        begin
            r.dq = {a.dq[lss_pkg::M_W-3:0], 2'b00};
            if (ts >= tr)
            begin
                r.sr   = lss_pkg::SR_W'(ts - tr);
                r.root = {a.root[lss_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                r.sr   = ts[lss_pkg::SR_W-1:0];
                r.root = {a.root[lss_pkg::Q_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic                          adv;
    logic                          mag_v_reg;
    lss_pkg::mag_t                 mag_reg;
    lss_pkg::mag_t                 mag_next;
    logic [lss_pkg::STEPS:0]       st_v_reg;
    lss_pkg::stage_t               st_reg [lss_pkg::STEPS+1];
    lss_pkg::stage_t               st_next [lss_pkg::STEPS+1];
    logic                          out_v_reg;
    logic [lss_pkg::COORD_W-1:0]   wf_reg, ws_reg, sf_reg, ss_reg;
    logic [lss_pkg::COORD_W-1:0]   wf_next, ws_next, sf_next, ss_next;
    logic                          dg_reg;
    lss_pkg::stage_t               fin;
    logic                          sat0, sat1, ssat;

    assign adv           = !out_v_reg || result_ready;
    assign pop           = adv && queue_valid;
    assign result_valid  = out_v_reg;
    assign weight_first  = wf_reg;
    assign weight_second = ws_reg;
    assign slope_first   = sf_reg;
    assign slope_second  = ss_reg;
    assign degenerate    = dg_reg;

    always_comb
    begin
        mag_next.s     = pop_item.s;
        mag_next.degen = pop_item.degen;
        mag_next.s_one = (pop_item.s == lss_pkg::S_W'(1));
        mag_next.neg0  = !pop_item.t0[lss_pkg::DOT_W-1];
        mag_next.neg1  = pop_item.t1[lss_pkg::DOT_W-1];
        mag_next.mag0  = pop_item.t0[lss_pkg::DOT_W-1] ?
                         lss_pkg::S_W'(-pop_item.t0) : lss_pkg::S_W'(pop_item.t0);
        mag_next.mag1  = pop_item.t1[lss_pkg::DOT_W-1] ?
                         lss_pkg::S_W'(-pop_item.t1) : lss_pkg::S_W'(pop_item.t1);
    end

    // Set up the dividers. A weight quotient that needs more than 32 bits is
    // flagged here, so the divider only has to make 32 quotient bits.
    always_comb
    begin
        st_next[0]       = '0;
        st_next[0].s     = mag_reg.s;
        st_next[0].degen = mag_reg.degen;
        st_next[0].s_one = mag_reg.s_one;
        st_next[0].neg0  = mag_reg.neg0;
        st_next[0].neg1  = mag_reg.neg1;
        st_next[0].ovf0  = ({16'h0, mag_reg.mag0} >= {mag_reg.s, 16'h0});
        st_next[0].ovf1  = ({16'h0, mag_reg.mag1} >= {mag_reg.s, 16'h0});
        st_next[0].wr0   = lss_pkg::S_W'(mag_reg.mag0 >> lss_pkg::FRAC_W);
        st_next[0].wr1   = lss_pkg::S_W'(mag_reg.mag1 >> lss_pkg::FRAC_W);
        st_next[0].wl0   = {mag_reg.mag0[lss_pkg::FRAC_W-1:0], 16'h0};
        st_next[0].wl1   = {mag_reg.mag1[lss_pkg::FRAC_W-1:0], 16'h0};
        st_next[0].dr    = lss_pkg::S_W'(1);
    end

    for (genvar j = 0; j < lss_pkg::STEPS; j++)
    begin : g_step
        always_comb
        begin
            st_next[j+1] = bk_step(st_reg[j], 1'(j < lss_pkg::W_STEPS),
                                   1'(j < lss_pkg::D_STEPS));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg <= mag_next;
            for (int k = 0; k <= lss_pkg::STEPS; k++)
            begin
                st_reg[k] <= st_next[k];
            end
            wf_reg <= wf_next;
            ws_reg <= ws_next;
            sf_reg <= sf_next;
            ss_reg <= ss_next;
            dg_reg <= fin.degen;
        end
    end

    assign fin  = st_reg[lss_pkg::STEPS];
    assign sat0 = fin.ovf0 || fin.wq0[lss_pkg::Q_W-1];
    assign sat1 = fin.ovf1 || fin.wq1[lss_pkg::Q_W-1];
    assign ssat = fin.s_one || fin.root[lss_pkg::Q_W-1];

    always_comb
    begin
        if (fin.degen)
        begin
            wf_next = '0;
            ws_next = '0;
            sf_next = '0;
            ss_next = '0;
        end
        else
        begin
            if (fin.neg0)
            begin
                wf_next = sat0 ? lss_pkg::SAT_MIN : lss_pkg::COORD_W'(-fin.wq0);
            end
            else
            begin
                wf_next = sat0 ? lss_pkg::SAT_MAX : fin.wq0;
            end
            if (fin.neg1)
            begin
                ws_next = sat1 ? lss_pkg::SAT_MIN : lss_pkg::COORD_W'(-fin.wq1);
            end
            else
            begin
                ws_next = sat1 ? lss_pkg::SAT_MAX : fin.wq1;
            end
            sf_next = ssat ? lss_pkg::SAT_MIN : lss_pkg::COORD_W'(-fin.root);
            ss_next = ssat ? lss_pkg::SAT_MAX : fin.root;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_v_reg <= 1'b0;
            st_v_reg  <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            mag_v_reg <= queue_valid;
            st_v_reg  <= {st_v_reg[lss_pkg::STEPS-1:0], mag_v_reg};
            out_v_reg <= st_v_reg[lss_pkg::STEPS];
        end
    end

endmodule

### design/linear_segment_shape_function.sv
// Stages from an accepted item to its result beat: 3 front stages
// (differences, products, dot sums), the queue, then 99 back stages
// (magnitudes, divider setup, 96 shift-subtract steps for the
// quotients and the square root, output). Throughput: one item per cycle
// while the output is not held. Reset clears all valid and queue state.
module linear_segment_shape_function
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic signed [lss_pkg::COORD_W-1:0] point_x,
    input  logic signed [lss_pkg::COORD_W-1:0] point_y,
    input  logic signed [lss_pkg::COORD_W-1:0] point_z,
    input  logic signed [lss_pkg::COORD_W-1:0] first_node_x,
    input  logic signed [lss_pkg::COORD_W-1:0] first_node_y,
    input  logic signed [lss_pkg::COORD_W-1:0] first_node_z,
    input  logic signed [lss_pkg::COORD_W-1:0] second_node_x,
    input  logic signed [lss_pkg::COORD_W-1:0] second_node_y,
    input  logic signed [lss_pkg::COORD_W-1:0] second_node_z,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [lss_pkg::COORD_W-1:0] weight_first,
    output logic signed [lss_pkg::COORD_W-1:0] weight_second,
    output logic signed [lss_pkg::COORD_W-1:0] slope_first,
    output logic signed [lss_pkg::COORD_W-1:0] slope_second,
    output logic                              degenerate
);

    logic           push;
    logic           pop;
    logic           queue_ready;
    logic           queue_valid;
    lss_pkg::item_t push_item;
    lss_pkg::item_t pop_item;

    lss_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .first_node_x  (first_node_x),
        .first_node_y  (first_node_y),
        .first_node_z  (first_node_z),
        .second_node_x (second_node_x),
        .second_node_y (second_node_y),
        .second_node_z (second_node_z),
        .push          (push),
        .push_item     (push_item),
        .queue_ready   (queue_ready)
    );

    lss_queue u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_item   (push_item),
        .queue_ready (queue_ready),
        .pop         (pop),
        .queue_valid (queue_valid),
        .pop_item    (pop_item)
    );

    lss_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_valid   (queue_valid),
        .pop_item      (pop_item),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .weight_first  (weight_first),
        .weight_second (weight_second),
        .slope_first   (slope_first),
        .slope_second  (slope_second),
        .degenerate    (degenerate)
    );

endmodule
